FILE: rtl/fpba_pkg.sv
package fpba_pkg;

    // Request kinds carried on the input tuser bit.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_FIT_POLICY  = 1'b0;
    localparam logic CFG_BLOCK_COUNT = 1'b1;

    localparam int CFG_DATA_W  = 7;
    localparam int SLOT_W      = 6;
    localparam int SIZE_PORT_W = 16;

    localparam logic [CFG_DATA_W-1:0] BLOCK_COUNT_RESET = 7'd64;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_BEST  = 2'd2,
        FIT_WORST = 2'd3
    } fit_policy_t;

    typedef struct packed {
        logic load_wr;     // store a block size from the input request
        logic scan_init;   // latch an allocate request and set up the scan
        logic scan_issue;  // read the next table entry
        logic commit;      // write back the chosen block and load the result
    } fpba_cmd_t;

    typedef struct packed {
        logic count_zero;  // no block in use
        logic last_issue;  // the read issued this cycle is the last one
        logic out_busy;    // result register still holds an untaken result
    } fpba_sts_t;

endpackage

FILE: rtl/fpba_ctrl.sv
module fpba_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tuser,
    output logic                  s_tready,
    input  fpba_pkg::fpba_sts_t   sts,
    output fpba_pkg::fpba_cmd_t   cmd
);
    import fpba_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tready && s_tvalid;

    always_comb
    begin
        cmd.load_wr    = accept && (s_tuser == REQ_LOAD);
        cmd.scan_init  = accept && (s_tuser == REQ_ALLOC);
        cmd.scan_issue = (state_reg == ST_SCAN);
        cmd.commit     = (state_reg == ST_COMMIT) && !sts.out_busy;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.scan_init)
                begin
                    // With no block in use there is nothing to read.
                    state_next = sts.count_zero ? ST_COMMIT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/fpba_datapath.sv
module fpba_datapath
#(
    parameter int MAX_BLOCKS = 64,
    parameter int SIZE_WIDTH = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [fpba_pkg::SLOT_W-1:0]          req_slot,
    input  logic [fpba_pkg::SIZE_PORT_W-1:0]     req_size,
    input  logic                                 m_tready,
    output logic                                 out_valid,
    output logic                                 out_granted,
    output logic [fpba_pkg::SLOT_W-1:0]          out_block,
    output logic [fpba_pkg::SIZE_PORT_W-1:0]     out_size,
    input  fpba_pkg::fpba_cmd_t                  cmd,
    output fpba_pkg::fpba_sts_t                  sts
);
    import fpba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = IDX_W + 1;

    logic [SIZE_WIDTH-1:0] mem [MAX_BLOCKS];

    fit_policy_t           policy_reg;
    logic [CFG_DATA_W-1:0] count_cfg_reg;

    logic [SIZE_WIDTH-1:0] rd_data_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  rd_valid_reg;

    logic [IDX_W-1:0]      pos_reg;
    logic [CNT_W-1:0]      remain_reg;
    logic [SIZE_WIDTH-1:0] size_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      pick_reg;
    logic [SIZE_WIDTH-1:0] pick_val_reg;
    logic [IDX_W-1:0]      rot_ptr_reg;

    logic                    out_valid_reg;
    logic                    out_granted_reg;
    logic [SLOT_W-1:0]       out_block_reg;
    logic [SIZE_PORT_W-1:0]  out_size_reg;

    logic [CNT_W-1:0]      count_eff;
    logic [IDX_W-1:0]      start_pos;
    logic [CNT_W-1:0]      pos_inc;
    logic [IDX_W-1:0]      pos_next;
    logic                  fits;
    logic                  take;
    logic [SIZE_WIDTH-1:0] new_val;
    logic                  slot_ok;

    // A block count above the table depth acts as the full table.
    assign count_eff = (32'(count_cfg_reg) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                               : CNT_W'(count_cfg_reg);

    // Next fit restarts at block 0 when the pointer lies beyond the blocks in use.
    assign start_pos = ((policy_reg == FIT_NEXT) && ({1'b0, rot_ptr_reg} < count_eff))
                       ? rot_ptr_reg : '0;

    assign pos_inc  = {1'b0, pos_reg} + CNT_W'(1);
    assign pos_next = (pos_inc == count_eff) ? '0 : IDX_W'(pos_inc);

    assign fits = (rd_data_reg >= size_reg);

    always_comb
    begin
        take = 1'b0;
        if (rd_valid_reg && fits)
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else
            begin
                case (policy_reg)
                    FIT_BEST:  take = (rd_data_reg < pick_val_reg);
                    FIT_WORST: take = (rd_data_reg > pick_val_reg);
                    default:   take = 1'b0;
                endcase
            end
        end
    end

    assign new_val = pick_val_reg - size_reg;
    assign slot_ok = (32'(req_slot) < 32'(MAX_BLOCKS));

    assign sts.count_zero = (count_eff == '0);
    assign sts.last_issue = cmd.scan_issue && (remain_reg == CNT_W'(1));
    assign sts.out_busy   = out_valid_reg && !m_tready;

    assign out_valid   = out_valid_reg;
    assign out_granted = out_granted_reg;
    assign out_block   = out_block_reg;
    assign out_size    = out_size_reg;

    // Block size table: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && slot_ok)
        begin
            mem[IDX_W'(req_slot)] <= SIZE_WIDTH'(req_size);
        end
        else if (cmd.commit && found_reg)
        begin
            mem[pick_reg] <= new_val;
        end
        rd_data_reg <= mem[pos_reg];
        rd_idx_reg  <= pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg      <= FIT_FIRST;
            count_cfg_reg   <= BLOCK_COUNT_RESET;
            rd_valid_reg    <= 1'b0;
            pos_reg         <= '0;
            remain_reg      <= '0;
            size_reg        <= '0;
            found_reg       <= 1'b0;
            pick_reg        <= '0;
            pick_val_reg    <= '0;
            rot_ptr_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_granted_reg <= 1'b0;
            out_block_reg   <= '0;
            out_size_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FIT_POLICY:  policy_reg    <= fit_policy_t'(cfg_data[1:0]);
                    CFG_BLOCK_COUNT: count_cfg_reg <= cfg_data;
                    default:         ;
                endcase
            end

            rd_valid_reg <= cmd.scan_issue;

            if (cmd.scan_init)
            begin
                size_reg   <= SIZE_WIDTH'(req_size);
                pos_reg    <= start_pos;
                remain_reg <= count_eff;
                found_reg  <= 1'b0;
            end
            else if (cmd.scan_issue)
            begin
                pos_reg    <= pos_next;
                remain_reg <= remain_reg - CNT_W'(1);
            end

            if (take)
            begin
                found_reg    <= 1'b1;
                pick_reg     <= rd_idx_reg;
                pick_val_reg <= rd_data_reg;
            end

            if (cmd.commit)
            begin
                out_valid_reg   <= 1'b1;
                out_granted_reg <= found_reg;
                out_block_reg   <= found_reg ? SLOT_W'(pick_reg) : '0;
                out_size_reg    <= found_reg ? SIZE_PORT_W'(new_val) : '0;
                if (found_reg && (policy_reg == FIT_NEXT))
                begin
                    rot_ptr_reg <= pick_reg;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/fit_policy_block_allocator_core.sv
// Channel   Direction  Signals                        Contents
// s_axis    in         s_tvalid s_tready s_tdata      load or allocate request
//                      s_tuser                        request kind
// m_axis    out        m_tvalid m_tready m_tdata      allocation result
//                      m_tuser                        granted flag
// cfg       in         cfg_we cfg_index cfg_data      fit policy, block count
//
// A load request writes its size into the table. An allocate request reads
// the block table through its single read port, one entry per cycle, over
// block_count entries (block_count capped at MAX_BLOCKS), skipping the scan
// when no block is in use. Reset is asynchronous and clears control state;
// table entries hold no value until loaded. A result waits in the output
// register while new requests are taken; the commit step stalls only when
// that register is still full.
module fit_policy_block_allocator_core
#(
    parameter int MAX_BLOCKS = 64,
    parameter int SIZE_WIDTH = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // block_slot[5:0], size_value[21:6]
    input  logic                              s_tuser,   // req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // granted_block[5:0], size_left[21:6]
    output logic                              m_tuser,   // granted
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fpba_pkg::*;

    fpba_cmd_t cmd;
    fpba_sts_t sts;

    logic [SLOT_W-1:0]      out_block;
    logic [SIZE_PORT_W-1:0] out_size;

    fpba_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fpba_datapath
    #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_WIDTH (SIZE_WIDTH)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_slot    (s_tdata[5:0]),
        .req_size    (s_tdata[21:6]),
        .m_tready    (m_tready),
        .out_valid   (m_tvalid),
        .out_granted (m_tuser),
        .out_block   (out_block),
        .out_size    (out_size),
        .cmd         (cmd),
        .sts         (sts)
    );

    assign m_tdata = {2'b00, out_size, out_block};

endmodule
